### rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Token kinds and keyword table for the markup tag tokenizer.
// ----------------------------------------------------------------------------
package mtt_pkg;

    typedef enum logic [4:0] {
        KIND_COMPLETE = 5'd0,
        KIND_SPACE    = 5'd1,
        KIND_EQ       = 5'd2,
        KIND_LT       = 5'd3,
        KIND_SLASH    = 5'd4,
        KIND_GT       = 5'd5,
        KIND_STRING   = 5'd6,
        KIND_TEXT     = 5'd7,
        KIND_UNKNOWN  = 5'd8,
        KIND_P        = 5'd9,
        KIND_IMG      = 5'd10,
        KIND_SPAN     = 5'd11,
        KIND_BR       = 5'd12,
        KIND_STRONG   = 5'd13,
        KIND_EM       = 5'd14,
        KIND_SRC      = 5'd15,
        KIND_A        = 5'd16,
        KIND_HREF     = 5'd17,
        KIND_CONTENT  = 5'd18
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] content;
        logic       last;
    } t_result;

    localparam int NUM_KEYS = 9;
    localparam int KEY_MAX  = 6;

    // Keywords right-aligned: the first letter sits in the highest used byte.
    localparam logic [8*KEY_MAX-1:0] KEY_TEXT [NUM_KEYS] = '{
        48'("p"), 48'("img"), 48'("span"), 48'("br"), 48'("strong"),
        48'("em"), 48'("src"), 48'("a"), 48'("href")
    };
    localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{
        3'd1, 3'd3, 3'd4, 3'd2, 3'd6, 3'd2, 3'd3, 3'd1, 3'd4
    };

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;

endpackage

### rtl/markup_tag_tokenizer.sv
// ----------------------------------------------------------------------------
// markup_tag_tokenizer
// Splits a byte stream into markup tokens: punctuation, quoted strings,
// keyword words and text runs, with content bytes streamed as they arrive.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata         | tuser      | tlast
//  s (byte) | in  | [7:0] ch      | -          | -
//  m (tok)  | out | [7:0] content | [4:0] kind | last result of the byte
//
//  A byte is taken in the cycle it is offered while the four-entry result
//  queue has two free slots; its zero, one or two results are pushed at once.
//  The queue drains one result per cycle while the output is ready, so a byte
//  that gives two results holds the output longer; one-result bytes stream at one per cycle.
//  Synchronous active-low reset empties the queue and returns to idle.
//  A stall on the output side holds the queue; input stalls once fewer than two slots are free.
// ----------------------------------------------------------------------------
module markup_tag_tokenizer #(
    parameter int MAX_WORD = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] ch
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] content
    output logic [7:0] o_m_tuser,    // [4:0] kind, [7:5] zero
    output logic       o_m_tlast
);
    import mtt_pkg::*;

    localparam int LW = $clog2(MAX_WORD + 2);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_WORD   = 2'd2,
        MODE_TEXT   = 2'd3
    } t_mode;

    typedef struct packed {
        logic       has;
        t_kind      kind;
        logic [7:0] content;
        t_mode      mode;
        logic       start_word;
    } t_idle;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic t_idle idle_byte(input logic [7:0] c);
        t_idle r;
        r = '{has: 1'b1, kind: KIND_COMPLETE, content: 8'h00,
              mode: MODE_IDLE, start_word: 1'b0};
        case (c)
            CH_END:   r.kind = KIND_COMPLETE;
            CH_SPACE: r.kind = KIND_SPACE;
            CH_EQ:    r.kind = KIND_EQ;
            CH_LT:    r.kind = KIND_LT;
            CH_SLASH: r.kind = KIND_SLASH;
            CH_GT:    r.kind = KIND_GT;
            CH_QUOTE: begin
                r.has  = 1'b0;
                r.mode = MODE_STRING;
            end
            default: begin
                if (is_letter(c)) begin
                    r.has        = 1'b0;
                    r.mode       = MODE_WORD;
                    r.start_word = 1'b1;
                end else begin
                    r.kind    = KIND_CONTENT;
                    r.content = c;
                    r.mode    = MODE_TEXT;
                end
            end
        endcase
        return r;
    endfunction

    t_mode           r_mode, n_mode;
    logic [7:0]      r_word [MAX_WORD];
    logic [LW-1:0]   r_word_len, n_word_len;
    t_result         r_queue [4];
    logic [1:0]      r_wr_ptr, r_rd_ptr;
    logic [2:0]      r_count, n_count;

    logic            s_accept, m_accept;
    logic [7:0]      ch;
    t_idle           idle_res;
    t_kind           word_kind;
    logic            key_hit, key_ok;
    t_result         res0, res1;
    logic [1:0]      push;
    logic            word_wr, word_first;

    assign ch         = i_s_tdata;
    assign o_s_tready = (r_count <= 3'd2);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_count != 3'd0);
    assign m_accept   = o_m_tvalid && i_m_tready;
    assign idle_res   = idle_byte(ch);

    // Keyword compare over the stored letters of the word.
    always_comb begin
        word_kind = KIND_UNKNOWN;
        key_hit   = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_ok = (r_word_len == LW'(KEY_LEN[k]));
            for (int i = 0; i < KEY_MAX; i++) begin
                if (i < int'(KEY_LEN[k]) &&
                    r_word[i] != KEY_TEXT[k][8*(int'(KEY_LEN[k]) - 1 - i) +: 8]) begin
                    key_ok = 1'b0;
                end
            end
            if (key_ok && !key_hit) begin
                key_hit   = 1'b1;
                word_kind = t_kind'(5'(int'(KIND_P) + k));
            end
        end
    end

    always_comb begin
        res0       = '{kind: KIND_COMPLETE, content: 8'h00, last: 1'b0};
        res1       = '{kind: KIND_COMPLETE, content: 8'h00, last: 1'b1};
        push       = 2'd0;
        n_mode     = r_mode;
        n_word_len = r_word_len;
        word_wr    = 1'b0;
        word_first = 1'b0;
        case (r_mode)
            MODE_STRING: begin
                push   = 2'd1;
                n_mode = MODE_IDLE;
                if (ch == CH_QUOTE) begin
                    res0.kind = KIND_STRING;
                end else if (ch == CH_END) begin
                    res0.kind = KIND_STRING;
                    push      = 2'd2;
                end else begin
                    res0.kind    = KIND_CONTENT;
                    res0.content = ch;
                    n_mode       = MODE_STRING;
                end
            end
            MODE_WORD: begin
                if (is_letter(ch)) begin
                    word_wr = (r_word_len < LW'(MAX_WORD));
                    if (r_word_len <= LW'(MAX_WORD)) begin
                        n_word_len = r_word_len + 1'b1;
                    end
                end else begin
                    // Close the word, then treat the byte as in idle.
                    res0.kind    = word_kind;
                    res1.kind    = idle_res.kind;
                    res1.content = idle_res.content;
                    push         = idle_res.has ? 2'd2 : 2'd1;
                    n_mode       = idle_res.mode;
                    n_word_len   = '0;
                    if (idle_res.start_word) begin
                        word_first = 1'b1;
                        n_word_len = LW'(1);
                    end
                end
            end
            MODE_TEXT: begin
                if (ch == CH_END || ch == CH_LT) begin
                    res0.kind    = KIND_TEXT;
                    res1.kind    = idle_res.kind;
                    res1.content = idle_res.content;
                    push         = 2'd2;
                    n_mode       = MODE_IDLE;
                end else begin
                    res0.kind    = KIND_CONTENT;
                    res0.content = ch;
                    push         = 2'd1;
                end
            end
            default: begin
                res0.kind    = idle_res.kind;
                res0.content = idle_res.content;
                push         = idle_res.has ? 2'd1 : 2'd0;
                n_mode       = idle_res.mode;
                if (idle_res.start_word) begin
                    word_first = 1'b1;
                    n_word_len = LW'(1);
                end
            end
        endcase
        res0.last = (push == 2'd1);
        if (!s_accept) begin
            push = 2'd0;
        end
        n_count = r_count + 3'(push) - 3'(m_accept);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_word_len <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_count <= n_count;
            if (m_accept) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (s_accept) begin
                r_mode     <= n_mode;
                r_word_len <= n_word_len;
                r_wr_ptr   <= r_wr_ptr + push;
            end
        end
        if (s_accept) begin
            for (int i = 0; i < MAX_WORD; i++) begin
                if ((word_wr && r_word_len == LW'(i)) || (word_first && i == 0)) begin
                    r_word[i] <= ch;
                end
            end
            if (push != 2'd0) begin
                r_queue[r_wr_ptr] <= res0;
            end
            if (push == 2'd2) begin
                r_queue[r_wr_ptr + 2'd1] <= res1;
            end
        end
    end

    assign o_m_tdata = r_queue[r_rd_ptr].content;
    assign o_m_tuser = {3'b000, r_queue[r_rd_ptr].kind};
    assign o_m_tlast = r_queue[r_rd_ptr].last;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    a_word_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_WORD |-> r_word_len != '0)
        else $error("word mode with empty word");

    a_end_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && ch == CH_END |=> r_mode == MODE_IDLE)
        else $error("end of input did not return to idle");

    a_complete_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[4:0] == KIND_COMPLETE |-> o_m_tlast)
        else $error("complete token not last of its byte");

endmodule
